[hdl/sbs_pkg.sv]
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants for the sorted table bound search block.
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned ENTRY_BITS_DEF  = 32;

  // fixed field widths of the stream beats
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned POS_W       = IDX_W + 1;
  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 16;

  // input tdata layout, lowest bit first
  localparam int unsigned WIDX_LSB = 0;
  localparam int unsigned WVAL_LSB = WIDX_LSB + IDX_W;
  localparam int unsigned RLO_LSB  = WVAL_LSB + VAL_W;
  localparam int unsigned RHI_LSB  = RLO_LSB + IDX_W;
  localparam int unsigned KEY_LSB  = RHI_LSB + IDX_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_LOWER = 2'd1,
    CMD_UPPER = 2'd2
  } cmd_e;

  // one classified operation: a write uses idx/operand, a query idx..hi/operand
  typedef struct packed {
    cmd_e                    cmd;
    logic [IDX_W-1:0]        idx;
    logic [IDX_W-1:0]        hi;
    logic signed [VAL_W-1:0] operand;
  } op_t;

endpackage

[hdl/sbs_front.sv]
// ----------------------------------------------------------------------------
// sbs_front
// Accepts input beats, drops those that do nothing, and registers the op.
// ----------------------------------------------------------------------------
module sbs_front #(
  parameter int unsigned TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sbs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [sbs_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                            op_valid_o,
  input  logic                            op_ready_i,
  output sbs_pkg::op_t                    op_o
);
  import sbs_pkg::*;

  logic vld_q, vld_d;
  op_t  op_q, op_d;
  cmd_e cmd;
  logic keep;
  logic accept;

  assign cmd           = cmd_e'(s_axis_tuser);
  assign s_axis_tready = !vld_q || op_ready_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    op_d.cmd = cmd;
    case (cmd)
      CMD_WRITE: begin
        keep       = 32'(s_axis_tdata[WIDX_LSB +: IDX_W]) < TABLE_DEPTH;
        op_d.idx   = s_axis_tdata[WIDX_LSB +: IDX_W];
        op_d.hi    = s_axis_tdata[RHI_LSB +: IDX_W];
        op_d.operand = s_axis_tdata[WVAL_LSB +: VAL_W];
      end
      CMD_LOWER, CMD_UPPER: begin
        keep       = 1'b1;
        op_d.idx   = s_axis_tdata[RLO_LSB +: IDX_W];
        op_d.hi    = s_axis_tdata[RHI_LSB +: IDX_W];
        op_d.operand = s_axis_tdata[KEY_LSB +: VAL_W];
      end
      default: begin
        // unused command: swallowed without a result
        keep       = 1'b0;
        op_d.idx   = s_axis_tdata[RLO_LSB +: IDX_W];
        op_d.hi    = s_axis_tdata[RHI_LSB +: IDX_W];
        op_d.operand = s_axis_tdata[KEY_LSB +: VAL_W];
      end
    endcase
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = keep;
    end else if (op_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_d;
    end
  end

  assign op_valid_o = vld_q;
  assign op_o       = op_q;

endmodule

[hdl/sbs_queue.sv]
// ----------------------------------------------------------------------------
// sbs_queue
// Two-entry op queue between the front and the search engine.
// ----------------------------------------------------------------------------
module sbs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          ready_o,
  input  sbs_pkg::op_t  op_i,
  output logic          valid_o,
  input  logic          pop_i,
  output sbs_pkg::op_t  op_o
);
  import sbs_pkg::*;

  localparam logic [1:0] FULL_CNT = 2'd2;

  op_t        slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign ready_o = count_q != FULL_CNT;
  assign valid_o = count_q != 2'd0;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign op_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

[hdl/sbs_back.sv]
// ----------------------------------------------------------------------------
// sbs_back
// Table memory and binary search engine, one probe per cycle, output register.
// ----------------------------------------------------------------------------
module sbs_back #(
  parameter int unsigned TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned ENTRY_BITS  = sbs_pkg::ENTRY_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_pop_o,
  input  sbs_pkg::op_t               q_op_i,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [sbs_pkg::POS_W-1:0]  m_pos_o,
  output logic                       m_not_found_o
);
  import sbs_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = (ENTRY_BITS > VAL_W) ? ENTRY_BITS : VAL_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [IDX_W-1:0]        lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, top_q, top_d;
  logic [IDX_W-1:0]        found_q, found_d;
  logic                    found_vld_q, found_vld_d;
  logic signed [VAL_W-1:0] key_q, key_d;
  logic                    upper_q, upper_d;
  logic                    out_vld_q, out_vld_d;
  logic [POS_W-1:0]        out_pos_q, out_pos_d;
  logic                    out_nf_q, out_nf_d;
  logic                    out_load;

  logic [ENTRY_BITS-1:0]   mem_q [TABLE_DEPTH];
  logic [ENTRY_BITS-1:0]   rd_data_q;
  logic                    rd_oor_q;
  logic                    rd_en, wr_en;
  logic [IDX_W-1:0]        rd_idx;

  logic signed [ENTRY_BITS-1:0] entry_s;
  logic signed [CW-1:0]         entry_ext, key_ext;
  logic                         ok;
  logic [POS_W-1:0]             sum_st, sum_dn, sum_up;
  logic [IDX_W-1:0]             mid_st, mid_dn, mid_up;

  // probe result; an index past the table reads as zero
  assign entry_s   = rd_oor_q ? '0 : $signed(rd_data_q);
  assign entry_ext = CW'(entry_s);
  assign key_ext   = CW'(key_q);
  assign ok        = upper_q ? (key_ext < entry_ext) : !(entry_ext < key_ext);

  // next midpoints for both outcomes, ready before the compare settles
  assign sum_st = POS_W'(q_op_i.idx) + POS_W'(q_op_i.hi);
  assign sum_dn = POS_W'(lo_q) + POS_W'(mid_q) - POS_W'(1);
  assign sum_up = POS_W'(mid_q) + POS_W'(1) + POS_W'(hi_q);
  assign mid_st = sum_st[POS_W-1:1];
  assign mid_dn = sum_dn[POS_W-1:1];
  assign mid_up = sum_up[POS_W-1:1];

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    top_d       = top_q;
    key_d       = key_q;
    upper_d     = upper_q;
    found_d     = found_q;
    found_vld_d = found_vld_q;
    q_pop_o     = 1'b0;
    rd_en       = 1'b0;
    rd_idx      = mid_q;
    wr_en       = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_op_i.cmd)
            CMD_WRITE: begin
              wr_en = 1'b1;
            end
            CMD_LOWER, CMD_UPPER: begin
              lo_d        = q_op_i.idx;
              hi_d        = q_op_i.hi;
              top_d       = q_op_i.hi;
              key_d       = q_op_i.operand;
              upper_d     = q_op_i.cmd == CMD_UPPER;
              found_vld_d = 1'b0;
              if (q_op_i.idx > q_op_i.hi) begin
                state_d = ST_DONE;
              end else begin
                mid_d   = mid_st;
                rd_idx  = mid_st;
                rd_en   = 1'b1;
                state_d = ST_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SRCH: begin
        if (ok) begin
          found_d     = mid_q;
          found_vld_d = 1'b1;
          if (mid_q == lo_q) begin
            state_d = ST_DONE;
          end else begin
            hi_d   = mid_q - IDX_W'(1);
            mid_d  = mid_dn;
            rd_idx = mid_dn;
            rd_en  = 1'b1;
          end
        end else begin
          if (mid_q == hi_q) begin
            state_d = ST_DONE;
          end else begin
            lo_d   = mid_q + IDX_W'(1);
            mid_d  = mid_up;
            rd_idx = mid_up;
            rd_en  = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_pos_d = out_pos_q;
    out_nf_d  = out_nf_q;
    if (out_load) begin
      out_vld_d = 1'b1;
      out_pos_d = found_vld_q ? POS_W'(found_q) : POS_W'(top_q) + POS_W'(1);
      out_nf_d  = !found_vld_q;
    end else if (m_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      found_vld_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      found_vld_q <= found_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    top_q     <= top_d;
    key_q     <= key_d;
    upper_q   <= upper_d;
    found_q   <= found_d;
    out_pos_q <= out_pos_d;
    out_nf_q  <= out_nf_d;
  end

  // table memory: one write or one read per cycle, registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AW'(q_op_i.idx)] <= ENTRY_BITS'($unsigned(q_op_i.operand));
    end
    if (rd_en) begin
      rd_data_q <= mem_q[AW'(rd_idx)];
      rd_oor_q  <= 32'(rd_idx) >= TABLE_DEPTH;
    end
  end

  assign m_valid_o     = out_vld_q;
  assign m_pos_o       = out_pos_q;
  assign m_not_found_o = out_nf_q;

  a_probe_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH) |-> (lo_q <= mid_q && mid_q <= hi_q))
    else $error("probe index outside search window");

  a_found_above_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH && found_vld_q) |-> (found_q > hi_q))
    else $error("search window not below best candidate");

  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && found_vld_q) |-> (found_q <= top_q))
    else $error("result beyond range high");

  a_write_no_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (state_q == ST_IDLE))
    else $error("table write started a search");

endmodule

[hdl/sorted_table_bound_search.sv]
// ----------------------------------------------------------------------------
// sorted_table_bound_search
// Table of signed entries with lower and upper bound binary search queries.
// ----------------------------------------------------------------------------
// Input beats on s_axis carry a command in tuser: write entry, lower bound or
// upper bound query. A write stores write_value at write_index and gives no
// output beat; writes beyond the table and unused commands are dropped. A
// query searches range_low..range_high for search_key and returns one beat on
// m_axis: position of the first qualifying entry, or range_high + 1 with
// not_found set. Load the table in ascending order before querying it.
// The search engine takes one op at a time; a query makes k halving steps,
// at most ceil(log2(range size + 1)) (11 for a full 1024-entry range), set
// by the single table read port, one probe per cycle.
// A stalled m_axis holds its beat; the search engine finishes its current
// query, then waits, while the front and a two-entry queue take beats until full.
// Reset clears control only; table contents stay undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_bound_search #(
  parameter int unsigned TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned ENTRY_BITS  = sbs_pkg::ENTRY_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // write_index, write_value, range_low, range_high, search_key, zero pad
  input  logic [sbs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [sbs_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // position, zero pad
  output logic [sbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // not_found
  output logic                            m_axis_tuser
);
  import sbs_pkg::*;

  op_t              front_op, queue_op;
  logic             front_vld, queue_rdy;
  logic             queue_vld, queue_pop;
  logic [POS_W-1:0] res_pos;

  sbs_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .op_valid_o    (front_vld),
    .op_ready_i    (queue_rdy),
    .op_o          (front_op)
  );

  sbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_vld),
    .ready_o (queue_rdy),
    .op_i    (front_op),
    .valid_o (queue_vld),
    .pop_i   (queue_pop),
    .op_o    (queue_op)
  );

  sbs_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (queue_vld),
    .q_pop_o       (queue_pop),
    .q_op_i        (queue_op),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_pos_o       (res_pos),
    .m_not_found_o (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TDATA_W'(res_pos);

endmodule
